>>> hw/rtl/polynomial_fit_mse_fitness_core_assert.svh
// Assertion macros for the polynomial fit core.
// Used by polynomial_fit_mse_fitness_core.sv; no other dependencies.
`ifndef POLYNOMIAL_FIT_MSE_FITNESS_CORE_ASSERT_SVH
`define POLYNOMIAL_FIT_MSE_FITNESS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define PF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PF_ASSERT(label, clk, rst_n, prop)
`define PF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hw/rtl/pfmse_pkg.sv
// Shared types and constants for the polynomial fit core.
// No dependencies.
package pfmse_pkg;
  localparam int unsigned MaxDegree = 6;
  localparam int unsigned CoefCount = MaxDegree + 1;
  localparam int unsigned MaxPoints = 65536;
  localparam int unsigned CntW = 17;
  localparam logic [2:0] REG_DEGREE = 3'd0;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    logic start;
    logic signed [63:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [63:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [64:0] v);
    if (v > $signed({{33{1'b0}}, S32_MAX})) begin
      return S32_MAX;
    end else if (v < $signed({{33{1'b1}}, S32_MIN})) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction
endpackage

>>> hw/rtl/pfmse_mul.sv
// Bit-serial signed multiplier: signed a times unsigned 32-bit b, one bit of b per cycle.
// Depends on pfmse_pkg.
module pfmse_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  pfmse_pkg::mul_req_t req,
  output pfmse_pkg::mul_rsp_t rsp
);
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0;
      a_nxt = req.a;
      b_nxt = req.b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt = a_r <<< 1;
      b_nxt = b_r >> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r;
endmodule

>>> hw/rtl/pfmse_div.sv
// Restoring divider for 64-bit unsigned values, one quotient bit per cycle.
// Depends on pfmse_pkg.
module pfmse_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pfmse_pkg::div_req_t req,
  output pfmse_pkg::div_rsp_t rsp
);
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[63:0], quo_r[63]};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.num;
      den_nxt = req.den;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[62:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo = quo_r;
endmodule

>>> hw/rtl/polynomial_fit_mse_fitness_core.sv
// Top level of the polynomial fit core: Horner evaluation, error sum and fitness.
// Depends on pfmse_pkg, pfmse_mul, pfmse_div and the assertion header.
//
//  channel | ports                                  | direction
//  in      | in_valid in_stall in_x/y_value in_last | into core
//  out     | out_valid out_stall out_mse/fitness    | out of core
//  cfg     | cfg_we cfg_index cfg_data              | into core
//
// Each point takes one multiplier pass per Horner step and one for the square,
// both on the bit-serial multiplier, plus the residual and accumulate steps; a
// last point adds two divider passes, the second skipped when the mean is zero or one.
// Reset is synchronous and clears the control state, the configuration registers and the error state.
// A held result in the output register does not block the next point, but a
// new result waits until the old one has been transferred.
`include "polynomial_fit_mse_fitness_core_assert.svh"
module polynomial_fit_mse_fitness_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_y_value,
  input  logic        in_last_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [62:0] out_mse,
  output logic [31:0] out_fitness,
  output logic        out_fitness_saturated
);
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_HORN = 7'b0000010,
    ST_SQR  = 7'b0000100,
    ST_ACC  = 7'b0001000,
    ST_DIV1 = 7'b0010000,
    ST_DIV2 = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  logic [2:0] degree_r;
  logic [31:0] coef_r [pfmse_pkg::CoefCount];
  logic [63:0] sum_r, sum_nxt;
  logic [pfmse_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic signed [31:0] x_r, y_r, acc_r, acc_nxt;
  logic last_r;
  logic [2:0] k_r, k_nxt;
  logic [63:0] mse_r, mse_nxt;
  logic vld_r, vld_nxt;
  logic [62:0] omse_r, omse_nxt;
  logic [31:0] ofit_r, ofit_nxt;
  logic osat_r, osat_nxt;
  logic issued_r, issued_nxt;
  pfmse_pkg::mul_req_t mreq;
  pfmse_pkg::mul_rsp_t mrsp;
  pfmse_pkg::div_req_t dreq;
  pfmse_pkg::div_rsp_t drsp;
  logic [2:0] deg_eff;
  logic signed [64:0] hsum;
  logic [31:0] mag;
  logic [64:0] ssum;
  logic in_acc;
  logic signed [64:0] resid;

  pfmse_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  pfmse_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign deg_eff = (degree_r > 3'(pfmse_pkg::MaxDegree)) ? 3'(pfmse_pkg::MaxDegree) : degree_r;
  assign in_stall = (st_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign hsum = 65'(mrsp.prod >>> 16) + 65'(signed'(coef_r[k_r - 3'd1]));
  assign resid = 65'(acc_r) - 65'(y_r);
  assign mag = acc_r[31] ? 32'(-acc_r) : acc_r;
  assign ssum = {1'b0, sum_r} + {1'b0, 16'd0, mrsp.prod[63:16]};

  always_comb begin
    st_nxt = st_r;
    acc_nxt = acc_r;
    k_nxt = k_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    mse_nxt = mse_r;
    vld_nxt = vld_r && out_stall;
    omse_nxt = omse_r;
    ofit_nxt = ofit_r;
    osat_nxt = osat_r;
    issued_nxt = issued_r;
    mreq = '0;
    dreq = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          acc_nxt = coef_r[deg_eff];
          k_nxt = deg_eff;
          issued_nxt = 1'b0;
          st_nxt = ST_HORN;
        end
      end
      ST_HORN: begin
        if (k_r == 3'd0) begin
          acc_nxt = pfmse_pkg::sat32(resid);
          issued_nxt = 1'b0;
          st_nxt = ST_SQR;
        end else if (!issued_r) begin
          mreq.start = 1'b1;
          mreq.a = 64'(acc_r);
          mreq.b = x_r;
          issued_nxt = 1'b1;
        end else if (mrsp.done) begin
          acc_nxt = pfmse_pkg::sat32(hsum - (x_r[31] ? (65'(acc_r) <<< 16) : 65'sd0));
          k_nxt = k_r - 3'd1;
          issued_nxt = 1'b0;
        end
      end
      ST_SQR: begin
        if (!issued_r) begin
          mreq.start = 1'b1;
          mreq.a = {32'd0, mag};
          mreq.b = mag;
          issued_nxt = 1'b1;
        end else if (mrsp.done) begin
          st_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_nxt = ssum[64] ? '1 : ssum[63:0];
        if (cnt_r < pfmse_pkg::CntW'(pfmse_pkg::MaxPoints)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        st_nxt = last_r ? ST_DIV1 : ST_IDLE;
        issued_nxt = 1'b0;
      end
      ST_DIV1: begin
        if (!issued_r) begin
          dreq.start = 1'b1;
          dreq.num = sum_r;
          dreq.den = 64'(cnt_r);
          issued_nxt = 1'b1;
        end else if (drsp.done) begin
          mse_nxt = drsp.quo[63] ? {1'b0, {63{1'b1}}} : drsp.quo;
          issued_nxt = 1'b0;
          st_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (mse_r <= 64'd1) begin
          st_nxt = ST_OUT;
        end else if (!issued_r) begin
          dreq.start = 1'b1;
          dreq.num = 64'h1_0000_0000;
          dreq.den = mse_r;
          issued_nxt = 1'b1;
        end else if (drsp.done) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!vld_r || !out_stall) begin
          vld_nxt = 1'b1;
          omse_nxt = mse_r[62:0];
          osat_nxt = (mse_r <= 64'd1);
          ofit_nxt = (mse_r <= 64'd1) ? '1 : drsp.quo[31:0];
          sum_nxt = '0;
          cnt_nxt = '0;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      degree_r <= '0;
      for (int i = 0; i < pfmse_pkg::CoefCount; i++) begin
        coef_r[i] <= '0;
      end
      sum_r <= '0;
      cnt_r <= '0;
      vld_r <= 1'b0;
      issued_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
      issued_r <= issued_nxt;
      if (cfg_we) begin
        if (cfg_index == pfmse_pkg::REG_DEGREE) begin
          degree_r <= cfg_data[2:0];
        end else begin
          coef_r[cfg_index - 3'd1] <= cfg_data;
        end
      end
    end
    if (in_acc) begin
      x_r <= in_x_value;
      y_r <= in_y_value;
      last_r <= in_last_point;
    end
    acc_r <= acc_nxt;
    k_r <= k_nxt;
    mse_r <= mse_nxt;
    omse_r <= omse_nxt;
    ofit_r <= ofit_nxt;
    osat_r <= osat_nxt;
  end

  assign out_valid = vld_r;
  assign out_mse = omse_r;
  assign out_fitness = ofit_r;
  assign out_fitness_saturated = osat_r;

  `PF_ASSERT(a_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_mse)))
  `PF_ASSERT(a_sat, clk, rst_n, (out_valid && out_fitness_saturated) |-> (out_fitness == '1))
  `PF_ASSERT(a_busy, clk, rst_n, (st_r != ST_IDLE) |-> in_stall)
endmodule

>>> sim/tb_polynomial_fit_mse_fitness_core.sv
// Testbench for polynomial_fit_mse_fitness_core: drives data points and register writes,
// predicts mean squared error and fitness per data set and checks every result transfer.
// Depends on pfmse_pkg and the core RTL.
`timescale 1ns / 100ps
module tb_polynomial_fit_mse_fitness_core;
  localparam logic [2:0] REG_COEF0 = 3'd1;

  typedef struct packed {
    logic [62:0] mse;
    logic [31:0] fitness;
    logic        saturated;
  } fit_result_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    logic        known;
    fit_result_t want;
  } point_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_x_value = '0;
  logic signed [31:0] in_y_value = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [62:0] out_mse;
  logic [31:0] out_fitness;
  logic out_fitness_saturated;

  polynomial_fit_mse_fitness_core u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_x_value(in_x_value),
    .in_y_value(in_y_value), .in_last_point(in_last_point), .out_valid(out_valid),
    .out_stall(out_stall), .out_mse(out_mse), .out_fitness(out_fitness),
    .out_fitness_saturated(out_fitness_saturated)
  );

  always #5 clk = ~clk;

  logic [2:0] deg_model;
  logic signed [31:0] coef_model [pfmse_pkg::CoefCount];
  logic [63:0] err_sum_model;
  logic [16:0] count_model;
  fit_result_t expected_results [$];
  int fail_count = 0;
  bit hold_off = 1'b0;
  bit quiet_out = 1'b0;

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] horner_value(input logic signed [31:0] x);
    logic signed [63:0] acc;
    int d;
    d = (deg_model > pfmse_pkg::MaxDegree) ? pfmse_pkg::MaxDegree : deg_model;
    acc = coef_model[d];
    for (int k = d; k > 0; k--) begin
      acc = ((acc * 64'(x)) >>> 16) + 64'(coef_model[k - 1]);
      acc = clamp32(acc);
    end
    return acc;
  endfunction

  task automatic accumulate_point(input logic [31:0] x, input logic [31:0] y,
                                  input logic last);
    logic signed [63:0] r;
    logic [63:0] mag, sq, q;
    fit_result_t res;
    r = clamp32(horner_value(x) - 64'($signed(y)));
    mag = r < 0 ? -r : r;
    sq = (mag * mag) >> 16;
    err_sum_model = (err_sum_model > ~64'd0 - sq) ? ~64'd0 : err_sum_model + sq;
    if (count_model < pfmse_pkg::MaxPoints) count_model++;
    if (last) begin
      q = err_sum_model / 64'(count_model);
      if (q[63]) q = 64'h7FFF_FFFF_FFFF_FFFF;
      res.mse = q[62:0];
      if (q <= 1) begin
        res.fitness = '1;
        res.saturated = 1'b1;
      end else begin
        res.fitness = 32'((64'd1 << 32) / q);
        res.saturated = 1'b0;
      end
      expected_results = {expected_results, res};
      err_sum_model = '0;
      count_model = '0;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pfmse_pkg::REG_DEGREE) deg_model = val[2:0];
    else coef_model[idx - 1] = val;
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic last,
                            input bit gaps);
    @(negedge clk);
    while (gaps && $urandom_range(99) < 25) @(negedge clk);
    in_valid <= 1'b1;
    in_x_value <= x;
    in_y_value <= y;
    in_last_point <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_point(x, y, last);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (quiet_out) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transfer mse=%h fitness=%h", $time, out_mse, out_fitness);
        fail_count++;
      end else begin
        fit_result_t e;
        e = expected_results.pop_front();
        if (out_mse !== e.mse) begin
          $display("%0t: mse expected %h actual %h", $time, e.mse, out_mse);
          fail_count++;
        end
        if (out_fitness !== e.fitness) begin
          $display("%0t: fitness expected %h actual %h", $time, e.fitness, out_fitness);
          fail_count++;
        end
        if (out_fitness_saturated !== e.saturated) begin
          $display("%0t: fitness_saturated expected %b actual %b", $time, e.saturated,
                   out_fitness_saturated);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #400ms;
    $display("CHECKS FAILED");
    $finish;
  end

  point_row_t directed [12];

  task automatic random_phase(input int n_points, input bit gaps);
    logic [31:0] x, y;
    for (int i = 0; i < n_points; i++) begin
      case ($urandom_range(3))
        0: x = $urandom();
        1: x = $urandom_range(32'h0004_0000) - 32'h0002_0000;
        2: x = {{16{1'b0}}, 16'($urandom())};
        default: x = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
      y = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0010_0000);
      send_point(x, y, ($urandom_range(5) == 0) || i == n_points - 1, gaps);
    end
  endtask

  initial begin
    int phase;
    deg_model = '0;
    foreach (coef_model[k]) coef_model[k] = '0;
    err_sum_model = '0;
    count_model = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Rows with a typed result are read off directly with all-zero registers.
    directed[0] = '{32'd0, 32'd0, 1'b1, 1'b1, '{63'd0, 32'hFFFF_FFFF, 1'b1}};
    directed[1] = '{32'd0, 32'h0001_0000, 1'b1, 1'b1, '{63'h1_0000, 32'h0001_0000, 1'b0}};
    directed[2] = '{32'd0, 32'h0002_0000, 1'b1, 1'b1, '{63'h4_0000, 32'h4000, 1'b0}};
    directed[3] = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '0};
    directed[4] = '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, '0};
    directed[5] = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, '0};
    directed[6] = '{32'h0001_0000, 32'h0000_8000, 1'b0, 1'b0, '0};
    directed[7] = '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, '0};
    directed[8] = '{32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, '0};
    directed[9] = '{32'hFFFF_0000, 32'h1234_5678, 1'b1, 1'b0, '0};
    directed[10] = '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0, '0};
    directed[11] = '{32'h5555_AAAA, 32'hAAAA_5555, 1'b1, 1'b0, '0};

    for (int i = 0; i < 12; i++) begin
      if (i == 3) begin
        drain_results();
        write_reg(pfmse_pkg::REG_DEGREE, 32'd6);
        for (int k = 0; k < pfmse_pkg::CoefCount; k++)
          write_reg(REG_COEF0 + 3'(k), (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
      end
      if (i == 9) begin
        drain_results();
        write_reg(pfmse_pkg::REG_DEGREE, 32'd2);
        write_reg(REG_COEF0, 32'h0001_0000);
        write_reg(REG_COEF0 + 3'd1, 32'hFFFF_8000);
        write_reg(REG_COEF0 + 3'd2, 32'h0000_4000);
      end
      if (directed[i].known) expected_results = {expected_results, directed[i].want};
      send_point(directed[i].x, directed[i].y, directed[i].last, 1'b0);
      if (directed[i].known) void'(expected_results.pop_back());
    end

    for (phase = 0; phase < 6; phase++) begin
      drain_results();
      write_reg(pfmse_pkg::REG_DEGREE,
                (phase == 0) ? 32'd0 : (phase == 1) ? 32'd6 : $urandom_range(7));
      for (int k = 0; k < pfmse_pkg::CoefCount; k++)
        write_reg(REG_COEF0 + 3'(k), (phase == 2) ? 32'h7FFF_FFFF :
                  ($urandom_range(1) ? $urandom() : $urandom_range(32'h0002_0000)));
      if (phase == 3) begin
        quiet_out = 1'b1;
        random_phase(60, 1'b0);
        quiet_out = 1'b0;
      end else if (phase == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (2000) @(posedge clk);
            hold_off = 1'b0;
          end
          random_phase(60, 1'b0);
        join
      end else begin
        random_phase(70, 1'b1);
      end
    end

    drain_results();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/pfmse_pkg.sv
hw/rtl/pfmse_mul.sv
hw/rtl/pfmse_div.sv
hw/rtl/polynomial_fit_mse_fitness_core.sv
sim/tb_polynomial_fit_mse_fitness_core.sv
